>>> rtl/csd_pkg.sv
package csd_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_FRAC   = 8;
    localparam int ACC_W      = 40;
    localparam int OUT_W      = 32;

    localparam int NUM_SHIFT = (FRAC_BITS >= OUT_FRAC) ? 0 : (OUT_FRAC - FRAC_BITS);
    localparam int DEN_SHIFT = (FRAC_BITS >= OUT_FRAC) ? (FRAC_BITS - OUT_FRAC) : 0;

    localparam int SQ_W  = 2 * DATA_WIDTH + NUM_SHIFT;
    localparam int DEN_W = DATA_WIDTH + DEN_SHIFT;
    localparam int CNT_W = $clog2(SQ_W);
    localparam int EXT_W = ((SQ_W > ACC_W) ? SQ_W : ACC_W) + 1;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [SQ_W-1:0]  num;
        logic [DEN_W-1:0] den;
        logic             pos;
        logic             last;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_ACC  = 3'b100
    } back_state_t;

endpackage

>>> rtl/csd_front.sv
module csd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [csd_pkg::DATA_WIDTH-1:0] elem_a,
    input  logic signed [csd_pkg::DATA_WIDTH-1:0] elem_b,
    input  logic                                last_element,
    input  csd_pkg::q_stat_t                    q_stat,
    output logic                                q_wr,
    output csd_pkg::item_t                      q_wdata
);

    localparam int DW = csd_pkg::DATA_WIDTH;

    logic                             stg_valid_reg, stg_valid_next;
    logic [DW-1:0]                    stg_abs_reg;
    logic [csd_pkg::DEN_W-1:0]        stg_den_reg;
    logic                             stg_pos_reg;
    logic                             stg_last_reg;

    logic                             accept;
    logic signed [DW:0]               sum_s;
    logic signed [DW:0]               diff_s;
    logic signed [DW:0]               diff_neg;
    logic [DW-1:0]                    abs_d;
    logic [2*DW-1:0]                  prod;

    assign full   = stg_valid_reg && q_stat.full;
    assign accept = push && !full;
    assign q_wr   = stg_valid_reg && !q_stat.full;

    assign sum_s    = (DW+1)'(elem_a) + (DW+1)'(elem_b);
    assign diff_s   = (DW+1)'(elem_a) - (DW+1)'(elem_b);
    assign diff_neg = -diff_s;
    assign abs_d    = diff_s[DW] ? diff_neg[DW-1:0] : diff_s[DW-1:0];

    assign prod = stg_abs_reg * stg_abs_reg;

    always_comb
    begin
        q_wdata.num  = csd_pkg::SQ_W'(prod) << csd_pkg::NUM_SHIFT;
        q_wdata.den  = stg_den_reg;
        q_wdata.pos  = stg_pos_reg;
        q_wdata.last = stg_last_reg;
    end

    always_comb
    begin
        if (accept)
        begin
            stg_valid_next = 1'b1;
        end
        else if (q_wr)
        begin
            stg_valid_next = 1'b0;
        end
        else
        begin
            stg_valid_next = stg_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_abs_reg  <= abs_d;
            stg_den_reg  <= csd_pkg::DEN_W'(sum_s[DW-1:0]) << csd_pkg::DEN_SHIFT;
            stg_pos_reg  <= !sum_s[DW] && (sum_s != '0);
            stg_last_reg <= last_element;
        end
    end

endmodule

>>> rtl/csd_queue.sv
module csd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  csd_pkg::item_t   wdata,
    input  logic             rd,
    output csd_pkg::item_t   rdata,
    output csd_pkg::q_stat_t stat
);

    localparam int AW = csd_pkg::Q_AW;

    csd_pkg::item_t  mem_reg [csd_pkg::Q_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == (AW+1)'(csd_pkg::Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rdata      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/csd_back.sv
module csd_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  csd_pkg::q_stat_t             q_stat,
    input  csd_pkg::item_t               q_rdata,
    output logic                         q_rd,
    input  logic                         pop,
    output logic                         empty,
    output logic [csd_pkg::OUT_W-1:0]    distance
);

    localparam int SQ_W  = csd_pkg::SQ_W;
    localparam int DEN_W = csd_pkg::DEN_W;
    localparam int EXT_W = csd_pkg::EXT_W;
    localparam int ACC_W = csd_pkg::ACC_W;
    localparam int OUT_W = csd_pkg::OUT_W;

    csd_pkg::back_state_t        state_reg, state_next;
    logic [SQ_W-1:0]             num_reg, num_next;
    logic [DEN_W-1:0]            rem_reg, rem_next;
    logic [DEN_W-1:0]            den_reg, den_next;
    logic                        last_reg, last_next;
    logic [csd_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ACC_W-1:0]            sum_reg, sum_next;
    logic                        out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]            out_reg, out_next;

    logic [DEN_W:0]              trial;
    logic                        ge;
    logic [EXT_W-1:0]            term_ext;
    logic [EXT_W-1:0]            term_sat;
    logic [EXT_W-1:0]            sum_ext;
    logic [ACC_W-1:0]            sum_acc;
    logic [ACC_W-2:0]            half;
    logic                        slot_free;

    assign empty     = !out_valid_reg;
    assign distance  = out_reg;
    assign slot_free = !out_valid_reg || pop;
    assign q_rd      = (state_reg == csd_pkg::ST_IDLE) && !q_stat.empty;

    assign trial = {rem_reg, num_reg[SQ_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    assign term_ext = EXT_W'(num_reg);
    assign term_sat = (term_ext > EXT_W'(csd_pkg::ACC_MAX)) ? EXT_W'(csd_pkg::ACC_MAX)
                                                             : term_ext;
    assign sum_ext  = EXT_W'(sum_reg) + term_sat;
    assign sum_acc  = (sum_ext > EXT_W'(csd_pkg::ACC_MAX)) ? csd_pkg::ACC_MAX
                                                            : sum_ext[ACC_W-1:0];
    assign half     = sum_acc[ACC_W-1:1];

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        case (state_reg)
            csd_pkg::ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    den_next  = q_rdata.den;
                    last_next = q_rdata.last;
                    rem_next  = '0;
                    cnt_next  = csd_pkg::CNT_W'(SQ_W - 1);
                    if (q_rdata.pos)
                    begin
                        num_next   = q_rdata.num;
                        state_next = csd_pkg::ST_DIV;
                    end
                    else
                    begin
                        num_next   = '0;
                        state_next = csd_pkg::ST_ACC;
                    end
                end
            end
            csd_pkg::ST_DIV:
            begin
                rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                num_next = {num_reg[SQ_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = csd_pkg::ST_ACC;
                end
            end
            csd_pkg::ST_ACC:
            begin
                if (!last_reg)
                begin
                    sum_next   = sum_acc;
                    state_next = csd_pkg::ST_IDLE;
                end
                else if (slot_free)
                begin
                    sum_next       = '0;
                    out_valid_next = 1'b1;
                    out_next       = (half[ACC_W-2:OUT_W] != '0) ? csd_pkg::OUT_MAX
                                                                 : half[OUT_W-1:0];
                    state_next     = csd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = csd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csd_pkg::ST_IDLE;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

endmodule

>>> rtl/chi_square_distance_stream.sv
// The back part takes one request at a time from the queue and finishes it before it takes
// the next: a request whose sum is positive goes through the divider, any other adds zero.
// The back part holds a one-bit-per-cycle restoring divider; a last request waits there
// until the result slot is free.
// The front stage and a two-entry queue take up to three requests ahead of the divider.
// Reset clears the running sum, the queue, the front stage and the pending result.
module chi_square_distance_stream (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [csd_pkg::DATA_WIDTH-1:0] elem_a,
    input  logic signed [csd_pkg::DATA_WIDTH-1:0] elem_b,
    input  logic                                  last_element,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [csd_pkg::OUT_W-1:0]             distance
);

    csd_pkg::q_stat_t q_stat;
    csd_pkg::item_t   q_wdata;
    csd_pkg::item_t   q_rdata;
    logic             q_wr;
    logic             q_rd;

    csd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .elem_a       (elem_a),
        .elem_b       (elem_b),
        .last_element (last_element),
        .q_stat       (q_stat),
        .q_wr         (q_wr),
        .q_wdata      (q_wdata)
    );

    csd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .rd    (q_rd),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    csd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_rdata  (q_rdata),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .distance (distance)
    );

endmodule

>>> bench/tb.sv
class chi_distance_book;
    logic [csd_pkg::ACC_W-1:0] acc_total;
    logic [csd_pkg::OUT_W-1:0] want_dist[$];

    function new();
        acc_total = '0;
    endfunction

    function logic [csd_pkg::ACC_W-1:0] chi_term(int a, int b);
        longint s;
        longint d;
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned den;
        longint unsigned q;
        s = longint'(a) + longint'(b);
        d = longint'(a) - longint'(b);
        if (s <= 0)
            return '0;
        mag = (d < 0) ? -d : d;
        sq = mag * mag;
        den = s;
        den = den << csd_pkg::DEN_SHIFT;
        q = (sq << csd_pkg::NUM_SHIFT) / den;
        if (q > csd_pkg::ACC_MAX)
            return csd_pkg::ACC_MAX;
        return q[csd_pkg::ACC_W-1:0];
    endfunction

    function void note_request(logic signed [csd_pkg::DATA_WIDTH-1:0] a,
                               logic signed [csd_pkg::DATA_WIDTH-1:0] b,
                               logic last);
        logic [csd_pkg::ACC_W-1:0] t;
        logic [csd_pkg::ACC_W-1:0] half;
        t = chi_term(int'(a), int'(b));
        if (t > csd_pkg::ACC_MAX - acc_total)
            acc_total = csd_pkg::ACC_MAX;
        else
            acc_total = acc_total + t;
        if (last)
        begin
            half = acc_total >> 1;
            if (half > csd_pkg::OUT_MAX)
                want_dist.push_back(csd_pkg::OUT_MAX);
            else
                want_dist.push_back(half[csd_pkg::OUT_W-1:0]);
            acc_total = '0;
        end
    endfunction

    function string check_distance(logic [csd_pkg::OUT_W-1:0] got);
        logic [csd_pkg::OUT_W-1:0] want;
        if (want_dist.size() == 0)
            return $sformatf("distance %h arrived with none expected", got);
        want = want_dist.pop_front();
        if (got !== want)
            return $sformatf("distance %h, expected %h", got, want);
        return "";
    endfunction

    function int outstanding();
        return want_dist.size();
    endfunction
endclass

module tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1700;
    localparam int SAT_LEN     = 320;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  push;
    logic                                  full;
    logic signed [csd_pkg::DATA_WIDTH-1:0] elem_a;
    logic signed [csd_pkg::DATA_WIDTH-1:0] elem_b;
    logic                                  last_element;
    logic                                  empty;
    logic                                  pop;
    logic [csd_pkg::OUT_W-1:0]             distance;

    chi_distance_book book;
    int errors;
    int cycles;
    int sent;
    int pop_wait;
    bit pop_steady;
    bit push_steady;
    string msg;

    chi_square_distance_stream i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .elem_a       (elem_a),
        .elem_b       (elem_b),
        .last_element (last_element),
        .empty        (empty),
        .pop          (pop),
        .distance     (distance)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(string text);
        $display("mismatch at cycle %0d: %s", cycles, text);
        errors++;
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (push_steady || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 100);
    endfunction

    function automatic int clip16(int v);
        if (v < -32768)
            return -32768;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    task automatic send_item(int a, int b, bit last);
        push         <= 1'b1;
        elem_a       <= a[csd_pkg::DATA_WIDTH-1:0];
        elem_b       <= b[csd_pkg::DATA_WIDTH-1:0];
        last_element <= last;
        do
            @(posedge clk);
        while (full);
        book.note_request(a[csd_pkg::DATA_WIDTH-1:0], b[csd_pkg::DATA_WIDTH-1:0], last);
        sent++;
    endtask

    task automatic idle(int n);
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_paced(int a, int b, bit last);
        send_item(a, b, last);
        idle(idle_len());
    endtask

    task automatic make_pair(output int a, output int b);
        int kind;
        int lim;
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            a = int'($urandom_range(0, 65535)) - 32768;
            b = int'($urandom_range(0, 65535)) - 32768;
        end
        else if (kind < 75)
        begin
            lim = ($urandom_range(0, 1) == 0) ? 1023 : 32767;
            a = $urandom_range(0, lim);
            b = $urandom_range(0, lim);
        end
        else if (kind < 90)
        begin
            a = int'($urandom_range(0, 65535)) - 32768;
            b = clip16(-a - int'($urandom_range(0, 3)));
        end
        else
        begin
            a = $urandom_range(0, 32767);
            b = clip16(1 + int'($urandom_range(0, 3)) - a);
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                msg = book.check_distance(distance);
                if (msg != "")
                    report_mismatch(msg);
            end
            if (pop_wait > 0)
            begin
                pop_wait--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (!pop_steady && $urandom_range(0, 5) == 0)
                    pop_wait = stall_len();
                if ($urandom_range(0, 199) == 0)
                    pop_steady = !pop_steady;
            end
        end
    end

    initial
    begin
        int a;
        int b;
        int len;
        int r;
        bit sat_done;
        bit paused;
        book = new();
        errors = 0;
        cycles = 0;
        sent = 0;
        pop_wait = 0;
        pop_steady = 1'b0;
        push_steady = 1'b0;
        sat_done = 1'b0;
        paused = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        elem_a = '0;
        elem_b = '0;
        last_element = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero pair, then sums at or below zero and a zero difference.
        send_paced(0, 0, 1'b1);
        send_paced(32767, -32768, 1'b0);
        send_paced(-32768, -32768, 1'b0);
        send_paced(-32768, 32767, 1'b0);
        send_paced(32767, 32767, 1'b1);
        // Largest terms with a sum of one, enough to clamp the output.
        send_paced(32767, -32766, 1'b0);
        send_paced(-32766, 32767, 1'b0);
        send_paced(32767, -32766, 1'b1);
        send_paced(256, 0, 1'b1);
        send_paced(1, 0, 1'b1);
        send_paced(100, -99, 1'b0);
        send_paced(21845, 10922, 1'b1);
        send_paced(-1, 2, 1'b1);
        send_paced(0, 1, 1'b0);
        send_paced(-32768, 0, 1'b0);
        send_paced(0, -1, 1'b1);

        while (sent < ITEM_TARGET)
        begin
            if (!sat_done && sent >= 600)
            begin
                // A long vector of huge terms drives the running sum into saturation.
                for (int i = 0; i < SAT_LEN; i++)
                begin
                    a = $urandom_range(30000, 32767);
                    send_paced(a, 1 - a, i == SAT_LEN - 1);
                end
                send_paced(256, 0, 1'b1);
                sat_done = 1'b1;
            end
            if (!paused && sent >= 1100)
            begin
                push <= 1'b0;
                do
                    @(posedge clk);
                while (book.outstanding() != 0);
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                push_steady = !push_steady;
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 6);
            else if (r < 95)
                len = $urandom_range(7, 20);
            else
                len = $urandom_range(21, 60);
            for (int i = 0; i < len; i++)
            begin
                make_pair(a, b);
                send_paced(a, b, i == len - 1);
            end
        end

        push <= 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> chi_square_distance_stream.f
rtl/csd_pkg.sv
rtl/csd_front.sv
rtl/csd_queue.sv
rtl/csd_back.sv
rtl/chi_square_distance_stream.sv
bench/tb.sv
